// ===== rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants of the strict UTF-8 string validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;

	localparam logic [ByteW-1:0] AsciiMax   = 8'h7f;
	localparam logic [ByteW-1:0] CtrlLimit  = 8'h20;
	localparam logic [ByteW-1:0] Lead2Min   = 8'hc2;
	localparam logic [ByteW-1:0] Lead2Max   = 8'hdf;
	localparam logic [ByteW-1:0] Lead3Min   = 8'he0;
	localparam logic [ByteW-1:0] Lead3Max   = 8'hef;
	localparam logic [ByteW-1:0] Lead4Min   = 8'hf0;
	localparam logic [ByteW-1:0] Lead4Max   = 8'hf4;
	localparam logic [1:0]       ContTag    = 2'b10;

	localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
	localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
	localparam logic [CpW-1:0] C1Min     = 21'h000080;
	localparam logic [CpW-1:0] C1Max     = 21'h00009f;
	localparam logic [CpW-1:0] SurrMin   = 21'h00d800;
	localparam logic [CpW-1:0] SurrMax   = 21'h00dfff;
	localparam logic [CpW-1:0] CpMax     = 21'h10ffff;

	localparam logic [1:0] SeqTwo   = 2'd1;
	localparam logic [1:0] SeqThree = 2'd2;
	localparam logic [1:0] SeqFour  = 2'd3;

	typedef struct packed {
		logic [1:0]     pending;
		logic [CpW-1:0] cp;
		logic [1:0]     seq_len;
		logic           failed;
	} dec_state_t;

	localparam dec_state_t StateClear = '{pending: 2'd0, cp: '0, seq_len: 2'd0, failed: 1'b0};

endpackage

// ===== rtl/utf8v_step.sv =====
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state and verdict logic for one byte of a string.
// ----------------------------------------------------------------------------
module utf8v_step (
	input  utf8v_pkg::dec_state_t          cur,
	input  logic [utf8v_pkg::ByteW-1:0]    data_byte,
	output utf8v_pkg::dec_state_t          nxt,
	output logic                           verdict
);

	logic [utf8v_pkg::CpW-1:0] cp_cat;
	logic [1:0]                pend_dec;
	logic                      seq_bad;

	assign cp_cat   = {cur.cp[utf8v_pkg::CpW-7:0], data_byte[5:0]};
	assign pend_dec = cur.pending - 2'd1;
	assign seq_bad  = (cur.seq_len == utf8v_pkg::SeqThree && cp_cat < utf8v_pkg::Min3Byte) ||
		(cur.seq_len == utf8v_pkg::SeqFour && cp_cat < utf8v_pkg::Min4Byte) ||
		(cp_cat >= utf8v_pkg::C1Min && cp_cat <= utf8v_pkg::C1Max) ||
		(cp_cat >= utf8v_pkg::SurrMin && cp_cat <= utf8v_pkg::SurrMax) ||
		(cp_cat > utf8v_pkg::CpMax);

	always_comb begin
		nxt = cur;
		if (!cur.failed) begin
			if (cur.pending == 2'd0) begin
				if (data_byte <= utf8v_pkg::AsciiMax) begin
					if (data_byte < utf8v_pkg::CtrlLimit || data_byte == utf8v_pkg::AsciiMax) begin
						nxt.failed = 1'b1;
					end
				end else if (data_byte >= utf8v_pkg::Lead2Min &&
					data_byte <= utf8v_pkg::Lead2Max) begin
					nxt.pending = utf8v_pkg::SeqTwo;
					nxt.seq_len = utf8v_pkg::SeqTwo;
					nxt.cp      = {16'd0, data_byte[4:0]};
				end else if (data_byte >= utf8v_pkg::Lead3Min &&
					data_byte <= utf8v_pkg::Lead3Max) begin
					nxt.pending = utf8v_pkg::SeqThree;
					nxt.seq_len = utf8v_pkg::SeqThree;
					nxt.cp      = {17'd0, data_byte[3:0]};
				end else if (data_byte >= utf8v_pkg::Lead4Min &&
					data_byte <= utf8v_pkg::Lead4Max) begin
					nxt.pending = utf8v_pkg::SeqFour;
					nxt.seq_len = utf8v_pkg::SeqFour;
					nxt.cp      = {18'd0, data_byte[2:0]};
				end else begin
					nxt.failed = 1'b1;
				end
			end else if (data_byte[7:6] != utf8v_pkg::ContTag) begin
				nxt.failed = 1'b1;
			end else begin
				nxt.pending = pend_dec;
				nxt.cp      = cp_cat;
				if (pend_dec == 2'd0) begin
					nxt.failed  = seq_bad;
					nxt.seq_len = 2'd0;
					nxt.cp      = '0;
				end
			end
		end
	end

	assign verdict = !nxt.failed && nxt.pending == 2'd0;

endmodule

// ===== rtl/utf8_string_validator_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_string_validator_unit
// Strict UTF-8 validation of byte strings, one verdict per string.
// ----------------------------------------------------------------------------
//   channel  handshake                   payload
//   input    in_valid / in_stall         data_byte, last
//   output   out_valid / out_stall       valid_res
//
// One byte is taken every cycle while in_stall is low; a verdict passes from its
// last byte through an input register and then a result register.
// Reset clears the decoder state and both valid flags.
// The input stalls only when a verdict is held by out_stall and the next
// registered byte also ends a string.
module utf8_string_validator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [utf8v_pkg::ByteW-1:0]  data_byte,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         valid_res
);

	logic                        vld_s1;
	logic [utf8v_pkg::ByteW-1:0] data_s1;
	logic                        last_s1;
	utf8v_pkg::dec_state_t       state_q;
	utf8v_pkg::dec_state_t       state_nxt;
	logic                        verdict;
	logic                        out_vld_q;
	logic                        res_q;
	logic                        out_free;
	logic                        adv_s1;

	assign out_free = !out_vld_q || !out_stall;
	assign adv_s1   = vld_s1 && (!last_s1 || out_free);
	assign in_stall = vld_s1 && !adv_s1;

	utf8v_step u_step (
		.cur       (state_q),
		.data_byte (data_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= utf8v_pkg::StateClear;
			out_vld_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= last_s1 ? utf8v_pkg::StateClear : state_nxt;
			end
			if (adv_s1 && last_s1) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= verdict;
		end
	end

	assign out_valid = out_vld_q;
	assign valid_res = res_q;

endmodule

// ===== rtl/utf8v_checker.sv =====
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks of the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module utf8v_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last,
	input logic out_valid,
	input logic out_stall,
	input logic valid_res
);

	// A held verdict keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(valid_res))
		else $error("verdict changed while stalled");

	// The input side only backs up behind a stalled verdict.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// A byte that does not end a string never produces a verdict.
	a_no_mid_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last) ##1 !out_valid |=> !out_valid)
		else $error("verdict emitted for a byte inside a string");

endmodule

bind utf8_string_validator_unit utf8v_checker u_utf8v_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.valid_res (valid_res)
);
